[hdl/fwsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsc_pkg
// Shared types and constants for the queue with associative search and remove.
// ----------------------------------------------------------------------------
package fwsc_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 2;
	localparam int IO_DATA_W   = 32;
	localparam int COUNT_OUT_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ    = 2'd0,
		CMD_DEQ    = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_COMPARE,
		S_SCAN,
		S_PUBLISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic compare;
		logic scan_step;
		logic commit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		cmd_t cmd;
		logic head_hit;
		logic scan_last;
		logic out_free;
	} dp_status_t;

endpackage

[hdl/fwsc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsc_ctrl
// Sequencer: takes one request, compares, scans for search and remove, then commits it.
// ----------------------------------------------------------------------------
module fwsc_ctrl
	import fwsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t dp_st,
	output ctrl_cmd_t  dp_cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_next = S_COMPARE;
				end
			end
			S_COMPARE: begin
				// Enqueue and dequeue need no search through the entries.
				if (dp_st.cmd == CMD_ENQ || dp_st.cmd == CMD_DEQ) begin
					state_next = S_PUBLISH;
				end else begin
					state_next = S_SCAN;
				end
			end
			S_SCAN: begin
				if (dp_st.head_hit || dp_st.scan_last) begin
					state_next = S_PUBLISH;
				end
			end
			S_PUBLISH: begin
				if (dp_st.out_free) begin
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready          = (state_q == S_IDLE);
		dp_cmd.load       = (state_q == S_IDLE) && in_valid;
		dp_cmd.compare    = (state_q == S_COMPARE);
		dp_cmd.scan_step  = (state_q == S_SCAN) && !(dp_st.head_hit || dp_st.scan_last);
		dp_cmd.commit     = (state_q == S_PUBLISH) && dp_st.out_free;
	end

endmodule

[hdl/fwsc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsc_datapath
// Entry cells with per-cell comparators, match scanner and result register.
// ----------------------------------------------------------------------------
module fwsc_datapath
	import fwsc_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
)(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   in_cmd,
	input  logic [IO_DATA_W-1:0]   in_data,
	input  ctrl_cmd_t              dp_cmd,
	output dp_status_t             dp_st,
	input  logic                   out_ready,
	output logic                   out_valid,
	output status_t                out_status,
	output logic [IO_DATA_W-1:0]   out_data,
	output logic [COUNT_OUT_W-1:0] out_count
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	logic [DATA_WIDTH-1:0] cell_q [DEPTH];
	logic [CNT_W-1:0]      count_q;
	cmd_t                  cmd_q;
	logic [DATA_WIDTH-1:0] key_q;
	logic [DEPTH-1:0]      match_q;
	logic [IDX_W-1:0]      pos_q;

	logic                  out_valid_q;
	status_t               out_status_q;
	logic [IO_DATA_W-1:0]  out_data_q;
	logic [COUNT_OUT_W-1:0] out_count_q;

	logic [63:0]           in_wide;
	logic [DEPTH-1:0]      match_vec;
	logic                  full;
	logic                  found;
	logic [CNT_W-1:0]      count_next;
	status_t               res_status;
	logic [DATA_WIDTH-1:0] res_word;
	logic [63:0]           res_wide;
	logic [8:0]            count_wide;

	assign in_wide = 64'(in_data);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign found   = match_q[0];

	// One comparator per cell; cells past the fill level never match.
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd_q == CMD_DEQ) begin
				match_vec[i] = (i == 0) && (count_q != '0);
			end else begin
				match_vec[i] = (cell_q[i] == key_q) && (CNT_W'(i) < count_q);
			end
		end
	end

	always_comb begin
		count_next = count_q;
		res_status = STAT_OK;
		res_word   = '0;
		unique case (cmd_q)
			CMD_ENQ: begin
				if (full) begin
					res_status = STAT_FULL;
				end else begin
					count_next = count_q + CNT_W'(1);
				end
			end
			CMD_DEQ: begin
				if (found) begin
					count_next = count_q - CNT_W'(1);
					res_word   = cell_q[0];
				end else begin
					res_status = STAT_MISS;
				end
			end
			CMD_SEARCH: begin
				res_status = found ? STAT_OK : STAT_MISS;
			end
			CMD_REMOVE: begin
				// A match is whole-word equal to the key, so the key is the word.
				if (found) begin
					count_next = count_q - CNT_W'(1);
					res_word   = key_q;
				end else begin
					res_status = STAT_MISS;
				end
			end
			default: res_status = STAT_MISS;
		endcase
	end

	assign res_wide   = 64'(res_word);
	assign count_wide = 9'(count_next);

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			key_q <= in_wide[DATA_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= CMD_ENQ;
			count_q <= '0;
			match_q <= '0;
			pos_q   <= '0;
		end else begin
			if (dp_cmd.load) begin
				cmd_q <= in_cmd;
			end
			if (dp_cmd.compare) begin
				match_q <= match_vec;
				pos_q   <= '0;
			end else if (dp_cmd.scan_step) begin
				match_q <= match_q >> 1;
				pos_q   <= pos_q + IDX_W'(1);
			end
			if (dp_cmd.commit) begin
				count_q <= count_next;
			end
		end
	end

	// Entry cells: append at the fill level, or close the gap left by a dequeue or a remove.
	always_ff @(posedge clk) begin
		if (dp_cmd.commit) begin
			for (int i = 0; i < DEPTH; i++) begin
				if (cmd_q == CMD_ENQ) begin
					if (!full && CNT_W'(i) == count_q) begin
						cell_q[i] <= key_q;
					end
				end else if ((cmd_q == CMD_DEQ || cmd_q == CMD_REMOVE) && found) begin
					if (i < DEPTH - 1 && IDX_W'(i) >= pos_q) begin
						cell_q[i] <= cell_q[(i < DEPTH - 1) ? i + 1 : i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.commit) begin
			out_status_q <= res_status;
			out_data_q   <= res_wide[IO_DATA_W-1:0];
			out_count_q  <= count_wide[COUNT_OUT_W-1:0];
		end
	end

	assign dp_st.cmd       = cmd_q;
	assign dp_st.head_hit  = match_q[0];
	assign dp_st.scan_last = (pos_q == IDX_W'(DEPTH - 1));
	assign dp_st.out_free  = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_data   = out_data_q;
	assign out_count  = out_count_q;

endmodule

[hdl/fifo_with_search_and_cancel_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_search_and_cancel_core
// Bounded queue with enqueue, dequeue, associative search and remove.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one request per beat: tuser holds the command,
// tdata the word to append or the key to look for. The master stream returns
// exactly one result per request: tuser holds the status, tdata the dequeued
// or removed word and the entry count after the request.
// Enqueue and dequeue go from compare straight to publish; search and remove
// first scan the registered match vector, which advances one entry per cycle
// until the entry at the head matches or the scan reaches the last cell.
// One request is in flight at a time; the next request is accepted in the
// cycle after its result is loaded into the output register.
// Reset empties the queue and drops any pending result; stored words are not
// cleared. When the receiver stalls, the finished result waits in the output
// register and the following request waits before its commit.
// ----------------------------------------------------------------------------
module fifo_with_search_and_cancel_core
	import fwsc_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] data_in
	input  logic [1:0]  s_axis_tuser,  // [1:0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [31:0] data_out, [36:32] entry_count, zero fill
	output logic [1:0]  m_axis_tuser   // [1:0] status
);

	ctrl_cmd_t               dp_cmd;
	dp_status_t              dp_st;
	status_t                 out_status;
	logic [IO_DATA_W-1:0]    out_data;
	logic [COUNT_OUT_W-1:0]  out_count;

	fwsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.dp_st    (dp_st),
		.dp_cmd   (dp_cmd)
	);

	fwsc_datapath #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_cmd     (cmd_t'(s_axis_tuser)),
		.in_data    (s_axis_tdata),
		.dp_cmd     (dp_cmd),
		.dp_st      (dp_st),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_status (out_status),
		.out_data   (out_data),
		.out_count  (out_count)
	);

	assign m_axis_tdata = {3'b000, out_count, out_data};
	assign m_axis_tuser = out_status;

endmodule

[hdl/fwsc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsc_checker
// Port-level checks on the queue's request and result streams.
// ----------------------------------------------------------------------------
module fwsc_checker
	import fwsc_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
)(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// A stalled result must hold.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// Only one request is in flight.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted while another is in flight");

	// Failed results carry a zero word; data-less results do too but go unchecked.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tdata[31:0] == 32'd0)
		else $error("nonzero word on a failed result");

	// A refused enqueue reports a full queue.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == STAT_FULL |->
			m_axis_tdata[36:32] == COUNT_OUT_W'(DEPTH))
		else $error("full status with a count below depth");

	// Results never report more entries than the queue holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && DEPTH < 32 |-> 32'(m_axis_tdata[36:32]) <= 32'(DEPTH))
		else $error("entry count above depth");

endmodule

bind fifo_with_search_and_cancel_core fwsc_checker #(.DEPTH(DEPTH)) u_fwsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

[tb/fwsc_queue_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsc_queue_checker
// Watches both streams of the queue core, keeps a shadow queue of the words it
// should hold, and compares every returned result with the one expected for
// the oldest open request.
// ----------------------------------------------------------------------------
module fwsc_queue_checker
	import fwsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	output int          error_count,
	output int          open_results
);

	typedef struct packed {
		status_t                  status;
		logic [IO_DATA_W-1:0]     word;
		logic [COUNT_OUT_W-1:0]   count;
	} queue_result_t;

	logic [DATA_WIDTH_DEF-1:0] held_words[$];
	queue_result_t             awaited_results[$];

	// Applies one request to the shadow queue and returns the result it earns.
	function automatic queue_result_t apply_request(cmd_t op, logic [31:0] key);
		queue_result_t r;
		int            hit_at;
		r.status = STAT_OK;
		r.word   = '0;
		hit_at   = -1;
		for (int i = 0; i < held_words.size(); i++) begin
			if (hit_at < 0 && held_words[i] == key)
				hit_at = i;
		end
		case (op)
			CMD_ENQ: begin
				if (held_words.size() >= DEPTH_DEF)
					r.status = STAT_FULL;
				else
					held_words.push_back(key);
			end
			CMD_DEQ: begin
				if (held_words.size() == 0)
					r.status = STAT_MISS;
				else
					r.word = held_words.pop_front();
			end
			CMD_SEARCH: begin
				if (hit_at < 0)
					r.status = STAT_MISS;
			end
			default: begin
				if (hit_at < 0) begin
					r.status = STAT_MISS;
				end else begin
					r.word = held_words[hit_at];
					held_words.delete(hit_at);
				end
			end
		endcase
		r.count = COUNT_OUT_W'(held_words.size());
		return r;
	endfunction

	always @(posedge clk) begin : watch
		queue_result_t want;
		int            errs;
		errs = 0;
		if (!arst_n) begin
			held_words.delete();
			awaited_results.delete();
			error_count  <= 0;
			open_results <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: result with no open request: status %0d word %h count %0d",
						$time, m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[36:32]);
					errs++;
				end else begin
					want = awaited_results.pop_front();
					if (m_axis_tuser != want.status) begin
						$display("%0t: status mismatch: expected %0d actual %0d",
							$time, want.status, m_axis_tuser);
						errs++;
					end
					if (m_axis_tdata[31:0] != want.word) begin
						$display("%0t: data_out mismatch: expected %h actual %h",
							$time, want.word, m_axis_tdata[31:0]);
						errs++;
					end
					if (m_axis_tdata[36:32] != want.count) begin
						$display("%0t: entry_count mismatch: expected %0d actual %0d",
							$time, want.count, m_axis_tdata[36:32]);
						errs++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				awaited_results.push_back(apply_request(cmd_t'(s_axis_tuser), s_axis_tdata));
			error_count  <= error_count + errs;
			open_results <= awaited_results.size();
		end
	end

endmodule

[tb/tb_fifo_with_search_and_cancel_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_with_search_and_cancel_core
// Drives directed and random enqueue, dequeue, search and remove requests with
// random gaps and output stalls, including one long output hold-off, and lets
// the checker judge every result against a shadow queue.
// ----------------------------------------------------------------------------
module tb_fifo_with_search_and_cancel_core;
	import fwsc_pkg::*;

	localparam int RANDOM_REQUESTS = 850;
	localparam int CYCLE_LIMIT     = 250000;
	localparam int DRAIN_CYCLES    = 2 * DEPTH_DEF + 8;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	int          error_count;
	int          open_results;
	int          requests_sent = 0;
	int          cycle_count = 0;
	int          results_seen = 0;
	int          ready_wait = 0;
	logic        rx_hold = 1'b0;
	logic        rx_calm = 1'b0;
	logic        tx_calm = 1'b0;
	logic [31:0] key_pool[8];

	always #10 clk = ~clk;

	fifo_with_search_and_cancel_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	fwsc_queue_checker checker_inst (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.error_count   (error_count),
		.open_results  (open_results)
	);

	// Offers one request after a random gap and returns at the edge that takes it.
	task automatic send_request(cmd_t op, logic [31:0] word);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= word;
		do @(posedge clk); while (!s_axis_tready);
		requests_sent++;
	endtask

	// Mostly words from a small pool so that searches and removes find matches.
	function automatic logic [31:0] pick_word();
		if ($urandom_range(0, 3) == 0)
			return $urandom;
		return key_pool[$urandom_range(0, 7)];
	endfunction

	always @(posedge clk) begin : rx_side
		int stall;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			ready_wait    <= 0;
		end else if (rx_hold) begin
			m_axis_tready <= 1'b0;
		end else if (ready_wait != 0) begin
			ready_wait    <= ready_wait - 1;
			m_axis_tready <= (ready_wait == 1);
		end else if (m_axis_tvalid && m_axis_tready) begin
			results_seen <= results_seen + 1;
			if (results_seen % 50 == 0)
				rx_calm <= ($urandom_range(0, 3) == 0);
			stall = rx_calm ? 0 : $urandom_range(0, 8);
			ready_wait    <= stall;
			m_axis_tready <= (stall == 0);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// One long output stall while requests keep coming, so the input backs up.
	initial begin
		wait (requests_sent >= 300);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (150) @(posedge clk);
		rx_hold <= 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int   r;
		logic fill_mode;
		cmd_t op;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= CMD_ENQ;
		key_pool[0] = 32'h0000_0000;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 8; i++)
			key_pool[i] = $urandom;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Requests on an empty queue.
		send_request(CMD_DEQ, 32'h0);
		send_request(CMD_REMOVE, 32'h0);
		send_request(CMD_SEARCH, 32'h0);
		// Extreme words and a duplicate, so remove must take the one nearer the head.
		send_request(CMD_ENQ, 32'h0000_0000);
		send_request(CMD_ENQ, 32'hFFFF_FFFF);
		send_request(CMD_ENQ, 32'hA5A5_A5A5);
		send_request(CMD_ENQ, 32'hFFFF_FFFF);
		send_request(CMD_SEARCH, 32'hFFFF_FFFF);
		send_request(CMD_SEARCH, 32'h1234_5678);
		send_request(CMD_REMOVE, 32'hFFFF_FFFF);
		send_request(CMD_REMOVE, 32'h5A5A_5A5A);
		// Fill to the brim, refuse one more, then remove the word at the tail.
		for (int i = 0; i < 13; i++)
			send_request(CMD_ENQ, (i == 12) ? 32'h8000_0001 : $urandom);
		send_request(CMD_ENQ, 32'h0000_0001);
		send_request(CMD_REMOVE, 32'h8000_0001);
		send_request(CMD_DEQ, 32'h0);

		// Random part: the mix swings between filling and draining phases.
		fill_mode = 1'b1;
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			if (i % 50 == 0) begin
				fill_mode = ~fill_mode;
				tx_calm <= ($urandom_range(0, 3) == 0);
			end
			r = $urandom_range(0, 99);
			if (fill_mode)
				op = (r < 60) ? CMD_ENQ : (r < 70) ? CMD_DEQ : (r < 85) ? CMD_SEARCH : CMD_REMOVE;
			else
				op = (r < 15) ? CMD_ENQ : (r < 55) ? CMD_DEQ : (r < 70) ? CMD_SEARCH : CMD_REMOVE;
			send_request(op, pick_word());
		end
		s_axis_tvalid <= 1'b0;

		@(posedge clk);
		while (open_results != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[fifo_with_search_and_cancel_core.f]
hdl/fwsc_pkg.sv
hdl/fwsc_ctrl.sv
hdl/fwsc_datapath.sv
hdl/fifo_with_search_and_cancel_core.sv
hdl/fwsc_checker.sv
tb/fwsc_queue_checker.sv
tb/tb_fifo_with_search_and_cancel_core.sv
